// ----- design/rst_pkg.sv -----
`default_nettype none
package rst_pkg;

    localparam int MAX_DEPTH  = 16;
    localparam int COUNT_BITS = 32;
    localparam int SP_W       = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // event codes
    localparam logic [3:0] EV_ARR_HDR   = 4'd0;
    localparam logic [3:0] EV_NULL_ARR  = 4'd1;
    localparam logic [3:0] EV_NULL_BULK = 4'd2;
    localparam logic [3:0] EV_BULK_HDR  = 4'd3;
    localparam logic [3:0] EV_DATA      = 4'd4;
    localparam logic [3:0] EV_STR_END   = 4'd5;
    localparam logic [3:0] EV_INT       = 4'd6;
    localparam logic [3:0] EV_BUF_OK    = 4'd7;
    localparam logic [3:0] EV_ERROR     = 4'd8;

    // string kinds
    localparam logic [1:0] SK_SIMPLE = 2'd0;
    localparam logic [1:0] SK_ERROR  = 2'd1;
    localparam logic [1:0] SK_BULK   = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_BAD_INT = 3'd2;
    localparam logic [2:0] ST_BAD_SEP = 3'd3;
    localparam logic [2:0] ST_UNEXP   = 3'd4;
    localparam logic [2:0] ST_BAD_SYM = 3'd5;
    localparam logic [2:0] ST_EXTRA   = 3'd6;
    localparam logic [2:0] ST_NO_MEM  = 3'd7;

    // protocol characters
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef struct packed {
        logic                  clear;
        logic                  finish;
        logic                  push;
        logic [COUNT_BITS-1:0] push_val;
    } t_stack_cmd;

    typedef struct packed {
        logic [SP_W-1:0] sp;
        logic [SP_W-1:0] closed;
        logic            top_after;
        logic            full;
    } t_stack_stat;

endpackage
`default_nettype wire

// ----- design/resp_stream_tokenizer.sv -----
`default_nettype none
// RESP2 stream tokenizer. Takes one byte per request and gives at most one
// token event per byte: array header, null array/bulk, bulk header, data
// byte, string end, integer, buffer ok or error. A byte sits in an input
// register, one pass of decode logic updates the parser state and the
// nesting stack, and the event lands in an output register, so a new
// byte is taken every cycle while the output is not stalled.
// Open arrays live on a MAX_DEPTH-entry stack of remaining-element counts;
// completion of a value pops all arrays it finishes in the same cycle.
// The first fault emits an error event and mutes the block until the byte
// flagged buffer_end, which restarts the parser (so does a clean end).
// single_value_mode (reset 1) may be written only while the block is idle.
module resp_stream_tokenizer
    import rst_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,
    // input byte channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_buffer_end,
    // event channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_event_res,
    output logic [1:0]       o_string_kind,
    output logic [7:0]       o_data_value,
    output logic signed [63:0] o_number,
    output logic [4:0]       o_nest_level,
    output logic [4:0]       o_closed_levels,
    output logic             o_top_done,
    output logic [2:0]       o_status
);
    typedef enum logic [2:0] {
        PH_TYPE, PH_HDR, PH_HLF, PH_DATA, PH_DCR, PH_DLF, PH_STR, PH_SLF
    } t_phase;

    typedef enum logic [2:0] {
        K_ARR, K_BULK, K_INT, K_SIMPLE, K_ERR
    } t_kind;

    // config
    logic r_svm;

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_buffer_end;
    logic       proceed;

    // parser state
    t_phase                r_phase, n_phase;
    t_kind                 r_hk, n_hk;
    logic [63:0]           r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic                  r_dig, n_dig;
    logic [COUNT_BITS-1:0] r_bulk, n_bulk;
    logic                  r_err_latched;
    logic                  r_top_seen, n_top_seen;

    // stack
    t_stack_cmd  stk_cmd;
    t_stack_stat stk_stat;

    // header digit unit
    logic [63:0] acc_next;
    logic        acc_ovf;

    // decode results
    logic        ev_valid;
    logic [3:0]  ev;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [63:0] num;
    logic [2:0]  err;
    logic        fin;
    logic        push;
    logic        restart;
    logic        has;
    logic [3:0]  o_ev;
    logic [1:0]  o_kind;
    logic [7:0]  o_data;
    logic [63:0] o_num;
    logic [4:0]  o_closed;
    logic        o_top;
    logic [2:0]  o_st;
    logic [SP_W-1:0] sp_after;
    logic        is_digit;
    logic        isnull;
    logic        wide;
    logic        bmo_cur;
    logic        bmo_next;
    logic [1:0]  str_kind;

    // output register
    logic        r_out_valid;
    logic [3:0]  r_event_res;
    logic [1:0]  r_string_kind;
    logic [7:0]  r_data_value;
    logic [63:0] r_number;
    logic [4:0]  r_nest_level;
    logic [4:0]  r_closed_levels;
    logic        r_top_done;
    logic [2:0]  r_status;

    assign o_cfg_ready = 1'b1;
    assign proceed     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !proceed;

    rst_hdr_num u_num (
        .i_acc   (r_acc),
        .i_neg   (r_neg),
        .i_digit (4'(r_in_byte - CH_0)),
        .o_acc   (acc_next),
        .o_ovf   (acc_ovf)
    );

    rst_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_stat  (stk_stat)
    );

    assign is_digit = (r_in_byte >= CH_0) && (r_in_byte <= CH_9);
    assign isnull   = r_neg && (r_acc == 64'd1);
    assign wide     = |(r_acc >> COUNT_BITS);
    assign bmo_cur  = (r_hk != K_INT) && r_neg && (r_acc >= 64'd2);
    assign str_kind = (r_hk == K_ERR) ? SK_ERROR : SK_SIMPLE;

    always_comb begin
        n_phase       = r_phase;
        n_hk          = r_hk;
        n_acc         = r_acc;
        n_neg         = r_neg;
        n_dig         = r_dig;
        n_bulk        = r_bulk;
        ev_valid      = 1'b0;
        ev            = EV_ARR_HDR;
        kind          = SK_SIMPLE;
        data          = '0;
        num           = '0;
        err           = ST_OK;
        fin           = 1'b0;
        push          = 1'b0;

        unique case (r_phase)
            PH_TYPE: begin
                if (r_svm && r_top_seen) begin
                    err = ST_EXTRA;
                end else begin
                    n_acc = '0;
                    n_neg = 1'b0;
                    n_dig = 1'b0;
                    unique case (r_in_byte)
                        CH_STAR:  begin n_hk = K_ARR;    n_phase = PH_HDR; end
                        CH_DOLL:  begin n_hk = K_BULK;   n_phase = PH_HDR; end
                        CH_COLON: begin n_hk = K_INT;    n_phase = PH_HDR; end
                        CH_PLUS:  begin n_hk = K_SIMPLE; n_phase = PH_STR; end
                        CH_MINUS: begin n_hk = K_ERR;    n_phase = PH_STR; end
                        default:  err = ST_BAD_SYM;
                    endcase
                end
            end
            PH_HDR: begin
                priority if (is_digit) begin
                    if (acc_ovf) begin
                        err = ST_BAD_INT;
                    end else begin
                        n_acc = acc_next;
                        n_dig = 1'b1;
                    end
                end else if (r_in_byte == CH_MINUS && !r_neg && !r_dig) begin
                    n_neg = 1'b1;
                end else if (!r_dig) begin
                    err = ST_BAD_INT;
                end else if (bmo_cur) begin
                    err = ST_BAD_INT;
                end else if (r_in_byte == CH_CR) begin
                    n_phase = PH_HLF;
                end else begin
                    err = ST_BAD_SEP;
                end
            end
            PH_HLF: begin
                if (r_in_byte != CH_LF) begin
                    err = ST_BAD_SEP;
                end else if (r_hk == K_INT) begin
                    num      = r_neg ? (64'd0 - r_acc) : r_acc;
                    fin      = 1'b1;
                    ev_valid = 1'b1;
                    ev       = EV_INT;
                end else if (r_hk == K_ARR) begin
                    priority if (isnull) begin
                        fin = 1'b1; ev_valid = 1'b1; ev = EV_NULL_ARR; num = '1;
                    end else if (wide) begin
                        err = ST_NO_MEM;
                    end else if (r_acc == 64'd0) begin
                        fin = 1'b1; ev_valid = 1'b1; ev = EV_ARR_HDR;
                    end else if (stk_stat.full) begin
                        err = ST_NO_MEM;
                    end else begin
                        push     = 1'b1;
                        n_phase  = PH_TYPE;
                        ev_valid = 1'b1;
                        ev       = EV_ARR_HDR;
                        num      = r_acc;
                    end
                end else begin
                    priority if (isnull) begin
                        fin = 1'b1; ev_valid = 1'b1; ev = EV_NULL_BULK; num = '1;
                    end else if (wide) begin
                        err = ST_NO_MEM;
                    end else begin
                        n_bulk   = r_acc[COUNT_BITS-1:0];
                        n_phase  = (r_acc != 64'd0) ? PH_DATA : PH_DCR;
                        ev_valid = 1'b1;
                        ev       = EV_BULK_HDR;
                        num      = r_acc;
                    end
                end
            end
            PH_DATA: begin
                if (r_buffer_end) begin
                    err = ST_UNEXP;
                end else begin
                    ev_valid = 1'b1;
                    ev       = EV_DATA;
                    kind     = SK_BULK;
                    data     = r_in_byte;
                    n_bulk   = r_bulk - COUNT_BITS'(1);
                    if (r_bulk == COUNT_BITS'(1)) begin
                        n_phase = PH_DCR;
                    end
                end
            end
            PH_DCR: begin
                priority if (r_buffer_end) begin
                    err = ST_UNEXP;
                end else if (r_in_byte != CH_CR) begin
                    err = ST_BAD_SEP;
                end else begin
                    n_phase = PH_DLF;
                end
            end
            PH_DLF: begin
                if (r_in_byte != CH_LF) begin
                    err = ST_BAD_SEP;
                end else begin
                    fin = 1'b1; ev_valid = 1'b1; ev = EV_STR_END; kind = SK_BULK;
                end
            end
            PH_STR: begin
                priority if (r_in_byte == CH_CR) begin
                    n_phase = PH_SLF;
                end else if (r_in_byte == CH_LF) begin
                    err = ST_BAD_SYM;
                end else begin
                    ev_valid = 1'b1; ev = EV_DATA; kind = str_kind; data = r_in_byte;
                end
            end
            PH_SLF: begin
                if (r_in_byte != CH_LF) begin
                    err = ST_BAD_SYM;
                end else begin
                    fin = 1'b1; ev_valid = 1'b1; ev = EV_STR_END; kind = str_kind;
                end
            end
            default: err = ST_BAD_SYM;
        endcase

        if (fin) begin
            n_phase = PH_TYPE;
        end
    end

    assign n_top_seen = r_top_seen | (fin & stk_stat.top_after);
    assign bmo_next   = (n_hk != K_INT) && n_neg && (n_acc >= 64'd2);
    assign sp_after   = push ? (stk_stat.sp + SP_W'(1)) :
                        fin  ? (stk_stat.sp - stk_stat.closed) : stk_stat.sp;

    // result selection: muted, fault, buffer end, or plain event
    always_comb begin
        has      = 1'b0;
        restart  = 1'b0;
        o_ev     = EV_ERROR;
        o_kind   = SK_SIMPLE;
        o_data   = '0;
        o_num    = '0;
        o_closed = '0;
        o_top    = 1'b0;
        o_st     = ST_OK;
        if (r_err_latched) begin
            restart = r_buffer_end;
        end else if (err != ST_OK) begin
            has     = 1'b1;
            o_st    = err;
            restart = r_buffer_end;
        end else if (r_buffer_end) begin
            has     = 1'b1;
            restart = 1'b1;
            if (n_phase == PH_TYPE && sp_after == '0) begin
                o_ev     = EV_BUF_OK;
                o_kind   = kind;
                o_data   = ev_valid ? {4'b0, ev} : {4'b0, EV_BUF_OK};
                o_num    = num;
                o_closed = fin ? 5'(stk_stat.closed) : 5'd0;
                o_top    = fin & stk_stat.top_after;
            end else begin
                unique case (n_phase)
                    PH_HDR: begin
                        if (!n_dig) begin
                            o_st = n_neg ? ST_BAD_INT : ST_EMPTY;
                        end else begin
                            o_st = bmo_next ? ST_BAD_INT : ST_BAD_SEP;
                        end
                    end
                    PH_HLF:  o_st = ST_BAD_SEP;
                    PH_SLF:  o_st = ST_BAD_SYM;
                    default: o_st = ST_UNEXP;
                endcase
            end
        end else if (ev_valid) begin
            has      = 1'b1;
            o_ev     = ev;
            o_kind   = kind;
            o_data   = data;
            o_num    = num;
            o_closed = fin ? 5'(stk_stat.closed) : 5'd0;
            o_top    = fin & stk_stat.top_after;
        end
    end

    // stack only moves on a clean, unmuted byte; restart clears it
    assign stk_cmd.clear    = proceed && restart;
    assign stk_cmd.finish   = proceed && !r_err_latched && (err == ST_OK) && fin;
    assign stk_cmd.push     = proceed && !r_err_latched && (err == ST_OK) && push;
    assign stk_cmd.push_val = r_acc[COUNT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svm         <= 1'b1;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_TYPE;
            r_hk          <= K_ARR;
            r_acc         <= '0;
            r_neg         <= 1'b0;
            r_dig         <= 1'b0;
            r_bulk        <= '0;
            r_err_latched <= 1'b0;
            r_top_seen    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_svm <= i_cfg_data;
            end

            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
                if (i_in_valid) begin
                    r_in_byte    <= i_in_byte;
                    r_buffer_end <= i_buffer_end;
                end
            end

            if (proceed) begin
                r_out_valid <= has;
                if (has) begin
                    r_event_res     <= o_ev;
                    r_string_kind   <= o_kind;
                    r_data_value    <= o_data;
                    r_number        <= o_num;
                    r_nest_level    <= 5'(stk_stat.sp);
                    r_closed_levels <= o_closed;
                    r_top_done      <= o_top;
                    r_status        <= o_st;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (proceed) begin
                if (restart) begin
                    r_phase       <= PH_TYPE;
                    r_hk          <= K_ARR;
                    r_acc         <= '0;
                    r_neg         <= 1'b0;
                    r_dig         <= 1'b0;
                    r_bulk        <= '0;
                    r_err_latched <= 1'b0;
                    r_top_seen    <= 1'b0;
                end else if (!r_err_latched) begin
                    if (err != ST_OK) begin
                        r_err_latched <= 1'b1;
                    end else begin
                        r_phase    <= n_phase;
                        r_hk       <= n_hk;
                        r_acc      <= n_acc;
                        r_neg      <= n_neg;
                        r_dig      <= n_dig;
                        r_bulk     <= n_bulk;
                        r_top_seen <= n_top_seen;
                    end
                end
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_res     = r_event_res;
    assign o_string_kind   = r_string_kind;
    assign o_data_value    = r_data_value;
    assign o_number        = r_number;
    assign o_nest_level    = r_nest_level;
    assign o_closed_levels = r_closed_levels;
    assign o_top_done      = r_top_done;
    assign o_status        = r_status;
endmodule
`default_nettype wire

// ----- design/rst_hdr_num.sv -----
`default_nettype none
module rst_hdr_num
    import rst_pkg::*;
(
    input  wire logic [63:0] i_acc,
    input  wire logic        i_neg,
    input  wire logic [3:0]  i_digit,
    output logic      [63:0] o_acc,
    output logic             o_ovf
);
    logic [67:0] prod;
    logic [67:0] lim;

    // acc*10 + d, checked against the int64 magnitude limit
    assign prod  = ({4'b0, i_acc} << 3) + ({4'b0, i_acc} << 1) + {64'b0, i_digit};
    assign lim   = i_neg ? {4'b0, 1'b1, 63'b0} : {5'b0, {63{1'b1}}};
    assign o_ovf = prod > lim;
    assign o_acc = prod[63:0];
endmodule
`default_nettype wire

// ----- design/rst_stack.sv -----
`default_nettype none
module rst_stack
    import rst_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_stack_cmd  i_cmd,
    output t_stack_stat      o_stat
);
    logic [COUNT_BITS-1:0] r_entry [MAX_DEPTH];
    logic [MAX_DEPTH-1:0]  r_one;   // entry holds exactly one element left
    logic [SP_W-1:0]       r_sp;

    logic [SP_W-1:0]       cnt;
    logic                  run;
    logic [SP_W-1:0]       nsp;
    logic [SP_W-1:0]       nsp_m1;
    logic [IDX_W-1:0]      idx;
    logic [COUNT_BITS-1:0] rd;

    // run of entries at the top that close on this completion
    always_comb begin
        cnt = '0;
        run = 1'b1;
        for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
            if (SP_W'(i) < r_sp) begin
                if (run && r_one[i]) begin
                    cnt = cnt + SP_W'(1);
                end else begin
                    run = 1'b0;
                end
            end
        end
    end

    assign nsp    = r_sp - cnt;
    assign nsp_m1 = nsp - SP_W'(1);
    assign idx    = nsp_m1[IDX_W-1:0];
    assign rd     = r_entry[idx];

    assign o_stat.sp        = r_sp;
    assign o_stat.closed    = cnt;
    assign o_stat.top_after = (nsp == '0);
    assign o_stat.full      = (r_sp == SP_W'(MAX_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_sp <= '0;
        end else if (i_cmd.push) begin
            r_entry[r_sp[IDX_W-1:0]] <= i_cmd.push_val;
            r_one[r_sp[IDX_W-1:0]]   <= (i_cmd.push_val == COUNT_BITS'(1));
            r_sp                     <= r_sp + SP_W'(1);
        end else if (i_cmd.finish) begin
            r_sp <= nsp;
            if (nsp != '0) begin
                r_entry[idx] <= rd - COUNT_BITS'(1);
                r_one[idx]   <= (rd == COUNT_BITS'(2));
            end
        end
    end
endmodule
`default_nettype wire
